[hw/rtl/rtcm3rx_pkg.sv]
`default_nettype none

package rtcm3rx_pkg;

   // Frame layout constants.
   localparam logic [7:0] PREAMBLE      = 8'hD3;
   localparam logic [1:0] HIGH_LEN_MASK = 2'b11;
   localparam logic [1:0] TRAILER_BYTES = 2'd3;
   localparam int         TYPE_BIT_POS  = 24;
   localparam int         TYPE_BITS     = 12;

   // Byte positions within the frame that hold the message type.
   localparam logic [10:0] TYPE_POS_HI = 11'(TYPE_BIT_POS / 8);
   localparam logic [10:0] TYPE_POS_LO = 11'(TYPE_BIT_POS / 8 + 1);

   // One result transaction.
   typedef struct packed {
      logic [7:0]           data_byte;
      logic                 in_frame;
      logic                 frame_start;
      logic                 frame_end;
      logic [TYPE_BITS-1:0] message_type;
      logic [10:0]          frame_length;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/rtcm3rx_parser.sv]
`default_nettype none

module rtcm3rx_parser
   import rtcm3rx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output result_type      result
);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_HEADER,
      PH_LENLOW,
      PH_PAYLOAD,
      PH_TRAILER
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [1:0]           len_high_ff, len_high_in;
   logic [9:0]           pay_len_ff, pay_len_in;
   logic [9:0]           pay_cnt_ff, pay_cnt_in;
   logic [1:0]           trl_cnt_ff, trl_cnt_in;
   logic [10:0]          byte_pos_ff, byte_pos_in;
   logic [TYPE_BITS-1:0] type_cap_ff, type_cap_in;
   logic [10:0]          pos_next;

   assign pos_next = byte_pos_ff + 11'd1;

   // Next state and result for the byte being accepted.
   always_comb begin
      phase_in    = phase_ff;
      len_high_in = len_high_ff;
      pay_len_in  = pay_len_ff;
      pay_cnt_in  = pay_cnt_ff;
      trl_cnt_in  = trl_cnt_ff;
      byte_pos_in = byte_pos_ff;
      type_cap_in = type_cap_ff;

      result              = '0;
      result.data_byte    = rx_byte;

      case (phase_ff)
         PH_HEADER, PH_LENLOW, PH_PAYLOAD, PH_TRAILER: begin
            result.in_frame = 1'b1;
            byte_pos_in     = pos_next;

            // Message type bits sit in byte three and the top nibble of byte four.
            if (pos_next == TYPE_POS_HI) begin
               type_cap_in = {rx_byte, 4'b0000};
            end else if (pos_next == TYPE_POS_LO) begin
               type_cap_in = {type_cap_ff[TYPE_BITS-1:4], rx_byte[7:4]};
            end

            case (phase_ff)
               PH_HEADER: begin
                  len_high_in = rx_byte[1:0] & HIGH_LEN_MASK;
                  phase_in    = PH_LENLOW;
               end
               PH_LENLOW: begin
                  pay_len_in = {len_high_ff, rx_byte};
                  phase_in   = ({len_high_ff, rx_byte} == 10'd0) ? PH_TRAILER : PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  if (pay_cnt_ff == pay_len_ff - 10'd1) begin
                     phase_in = PH_TRAILER;
                  end
                  pay_cnt_in = pay_cnt_ff + 10'd1;
               end
               default: begin
                  trl_cnt_in = trl_cnt_ff + 2'd1;
                  if (trl_cnt_in == TRAILER_BYTES) begin
                     result.frame_end    = 1'b1;
                     result.message_type = type_cap_in;
                     result.frame_length = pos_next + 11'd1;
                     phase_in            = PH_HUNT;
                  end
               end
            endcase
         end
         default: begin
            // Hunting; unused codes fall back here as well.
            phase_in = PH_HUNT;
            if (rx_byte == PREAMBLE) begin
               result.in_frame    = 1'b1;
               result.frame_start = 1'b1;
               byte_pos_in        = '0;
               pay_cnt_in         = '0;
               trl_cnt_in         = '0;
               type_cap_in        = '0;
               phase_in           = PH_HEADER;
            end
         end
      endcase
   end

   // Parser state, updated once per accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         len_high_ff <= '0;
         pay_len_ff  <= '0;
         pay_cnt_ff  <= '0;
         trl_cnt_ff  <= '0;
         byte_pos_ff <= '0;
         type_cap_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         len_high_ff <= len_high_in;
         pay_len_ff  <= pay_len_in;
         pay_cnt_ff  <= pay_cnt_in;
         trl_cnt_ff  <= trl_cnt_in;
         byte_pos_ff <= byte_pos_in;
         type_cap_ff <= type_cap_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/rtcm3_frame_receiver_top.sv]
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    rx_byte (8)
// rsp_      out        rsp_valid/stall    data_byte, in_frame, frame_start, frame_end,
//                                         message_type (12), frame_length (11)
//
// One byte per cycle is accepted while req_stall is low; each byte gives exactly one result,
// held in the result register or the skid entry. The parser state register and its combinational
// next-state logic set that rate. Reset is synchronous and returns the parser to hunting for a preamble.
// A two-entry output buffer (result register plus skid) keeps input flowing
// for one more byte after the result side stalls; req_stall rises only when both are full.
`default_nettype none

module rtcm3_frame_receiver_top
   import rtcm3rx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_in_frame,
   output logic             rsp_frame_start,
   output logic             rsp_frame_end,
   output logic [11:0]      rsp_message_type,
   output logic [10:0]      rsp_frame_length
);

   logic       accept;
   logic       out_free;
   result_type result;
   result_type out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   rtcm3rx_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   // Output buffer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Output buffer payload.
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_in_frame     = out_ff.in_frame;
   assign rsp_frame_start  = out_ff.frame_start;
   assign rsp_frame_end    = out_ff.frame_end;
   assign rsp_message_type = out_ff.message_type;
   assign rsp_frame_length = out_ff.frame_length;

   // The skid entry is only used behind a held result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without a held result");

   // A frame end is always in a frame and carries a frame length of at least six bytes.
   a_end_length: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.frame_end) |-> (out_ff.in_frame && out_ff.frame_length >= 11'd6))
      else $error("frame end with bad length or outside a frame");

   // Summary fields are zero except on a frame end.
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.frame_end) |->
         (out_ff.message_type == '0 && out_ff.frame_length == '0))
      else $error("summary fields set outside a frame end");

   // A start byte is in a frame and never ends one.
   a_start_marks: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.frame_start) |-> (out_ff.in_frame && !out_ff.frame_end))
      else $error("bad marks on a frame start");

   // A new byte taken while the output buffer is full would be lost.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("skid entry dropped while result stalled");

endmodule

`default_nettype wire

[dv/rtcm3_frame_receiver_top_tb.sv]
`default_nettype none

module rtcm3_frame_receiver_top_tb;
   import rtcm3rx_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   typedef logic [7:0] byte_seq_type[$];

   // Parser phases of the deframer being mirrored.
   typedef enum logic [2:0] {
      PH_HUNT,
      PH_HEADER,
      PH_LENLOW,
      PH_PAYLOAD,
      PH_TRAILER
   } deframe_phase_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_data_byte;
   logic        rsp_in_frame;
   logic        rsp_frame_start;
   logic        rsp_frame_end;
   logic [11:0] rsp_message_type;
   logic [10:0] rsp_frame_length;

   // Mirror of the deframer state.
   deframe_phase_type parse_phase;
   logic [1:0]        len_high;
   logic [9:0]        payload_len;
   logic [9:0]        payload_seen;
   logic [1:0]        trailer_seen;
   logic [10:0]       frame_pos;
   logic [11:0]       type_bits;

   result_type tagged_bytes_due[$];
   result_type oldest_due;

   int errors = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   rtcm3_frame_receiver_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_in_frame    (rsp_in_frame),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_message_type(rsp_message_type),
      .rsp_frame_length(rsp_frame_length)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: the run must finish well within the cycle budget.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Random backpressure on the result channel.
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99, 0) < rsp_stall_pct);
   end

   task automatic clear_deframe_state();
      parse_phase  = PH_HUNT;
      len_high     = '0;
      payload_len  = '0;
      payload_seen = '0;
      trailer_seen = '0;
      frame_pos    = '0;
      type_bits    = '0;
   endtask

   // Advance the mirrored deframer by one byte and queue the tagged byte it yields.
   task automatic deframe_byte(input logic [7:0] rx);
      result_type predicted;
      predicted = '0;
      predicted.data_byte = rx;
      if (parse_phase == PH_HUNT) begin
         if (rx == PREAMBLE) begin
            predicted.in_frame    = 1'b1;
            predicted.frame_start = 1'b1;
            frame_pos    = '0;
            payload_seen = '0;
            trailer_seen = '0;
            type_bits    = '0;
            parse_phase  = PH_HEADER;
         end
      end else begin
         predicted.in_frame = 1'b1;
         frame_pos = frame_pos + 11'd1;
         // The message type is byte 3 in full plus the high nibble of byte 4.
         if (frame_pos == TYPE_POS_HI) begin
            type_bits = {rx, 4'h0};
         end else if (frame_pos == TYPE_POS_LO) begin
            type_bits[3:0] = rx[7:4];
         end
         case (parse_phase)
            PH_HEADER: begin
               len_high    = rx[1:0] & HIGH_LEN_MASK;
               parse_phase = PH_LENLOW;
            end
            PH_LENLOW: begin
               payload_len = {len_high, rx};
               parse_phase = (payload_len == 10'd0) ? PH_TRAILER : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (payload_seen == payload_len - 10'd1) parse_phase = PH_TRAILER;
               payload_seen = payload_seen + 10'd1;
            end
            PH_TRAILER: begin
               trailer_seen = trailer_seen + 2'd1;
               if (trailer_seen == TRAILER_BYTES) begin
                  predicted.frame_end    = 1'b1;
                  predicted.message_type = type_bits;
                  predicted.frame_length = frame_pos + 11'd1;
                  parse_phase = PH_HUNT;
               end
            end
            default: begin
               parse_phase = PH_HUNT;
            end
         endcase
      end
      tagged_bytes_due.push_back(predicted);
   endtask

   function automatic void compare_field(input string name, input logic [11:0] want,
                                         input logic [11:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   // Check every accepted result transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tagged_bytes_due.size() == 0) begin
            $error("unexpected result transaction: data_byte 0x%0h", rsp_data_byte);
            errors++;
         end else begin
            oldest_due = tagged_bytes_due.pop_front();
            compare_field("data_byte", 12'(oldest_due.data_byte), 12'(rsp_data_byte));
            compare_field("in_frame", 12'(oldest_due.in_frame), 12'(rsp_in_frame));
            compare_field("frame_start", 12'(oldest_due.frame_start), 12'(rsp_frame_start));
            compare_field("frame_end", 12'(oldest_due.frame_end), 12'(rsp_frame_end));
            compare_field("message_type", oldest_due.message_type, rsp_message_type);
            compare_field("frame_length", 12'(oldest_due.frame_length),
                          12'(rsp_frame_length));
         end
      end
   end

   // Send one byte; entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid   = 1'b0;
         req_rx_byte = 8'($urandom);
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      deframe_byte(value);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_sequence(input byte_seq_type seq);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // Stop sending and wait until every predicted result has been seen.
   task automatic drain_results();
      req_valid = 1'b0;
      while (tagged_bytes_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Build one frame with random header spare bits, payload and trailer.
   // A truncated frame stops somewhere after its preamble.
   task automatic send_frame(input logic [9:0] len, input bit truncate);
      logic [7:0] frame_bytes[$];
      int keep;
      frame_bytes.push_back(PREAMBLE);
      frame_bytes.push_back({6'($urandom), len[9:8]});
      frame_bytes.push_back(len[7:0]);
      for (int i = 0; i < int'(len) + 3; i++) begin
         frame_bytes.push_back(($urandom_range(15, 0) == 0) ? PREAMBLE : 8'($urandom));
      end
      keep = truncate ? int'($urandom_range(frame_bytes.size() - 1, 1)) : frame_bytes.size();
      for (int i = 0; i < keep; i++) send_byte(frame_bytes[i]);
   endtask

   // Bytes outside any frame, including two that are each one bit off the preamble.
   task automatic test_hunt_noise();
      send_sequence('{8'h00, 8'hFF, 8'hD2, 8'h53});
   endtask

   // Empty payload with spare header bits set; the type comes from the trailer.
   task automatic test_zero_length_frame();
      send_sequence('{PREAMBLE, 8'hFC, 8'h00, 8'hAB, 8'hCD, 8'hEF});
   endtask

   // One and two byte payloads, with a preamble value inside each frame.
   task automatic test_short_payload_frames();
      send_sequence('{PREAMBLE, 8'h00, 8'h01, PREAMBLE, 8'h5A, 8'h12, 8'h34});
      send_sequence('{PREAMBLE, 8'h80, 8'h02, 8'h3E, 8'h7F, PREAMBLE, 8'hFF, 8'h00});
   endtask

   // Largest payload, so both high length bits are set.
   task automatic test_max_length_frame();
      send_frame(10'h3FF, 1'b0);
      drain_results();
   endtask

   // Mostly well-formed frames of random content, with noise and truncated frames mixed in.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n_items);
      int stop_at;
      int pick;
      logic [9:0] len;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(99, 0) < 12) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
         end
         pick = $urandom_range(99, 0);
         if (pick < 88) begin
            len = 10'($urandom_range(12, 0));
         end else if (pick < 98) begin
            len = 10'($urandom_range(80, 13));
         end else begin
            len = {2'($urandom_range(2, 1)), 8'($urandom_range(31, 0))};
         end
         send_frame(len, $urandom_range(99, 0) < 8);
      end
      drain_results();
   endtask

   // Test sequence.
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      rsp_stall   = 1'b0;
      clear_deframe_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_hunt_noise();
      test_zero_length_frame();
      test_short_payload_frames();
      drain_results();
      test_max_length_frame();
      test_random_traffic(0, 0, 90);
      test_random_traffic(85, 0, 90);
      test_random_traffic(0, 85, 90);
      test_random_traffic(22, 22, 90);

      rsp_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (tagged_bytes_due.size() != 0) begin
         $error("%0d predicted result transactions never arrived", tagged_bytes_due.size());
         errors++;
      end
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hw/rtl/rtcm3rx_pkg.sv
hw/rtl/rtcm3rx_parser.sv
hw/rtl/rtcm3_frame_receiver_top.sv
dv/rtcm3_frame_receiver_top_tb.sv
